// ===== src/lcbi_pkg.sv =====
// Shared types and constants of the linear / cubic blend interpolator.
// Used by the top level and by the long-division unit; depends on nothing.
`default_nettype none

package lcbi_pkg;

  // Command codes of an input item.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_KNOTS = 1'b0;
  localparam logic CFG_BLEND = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // Unit of the interval fraction t, Q1.30.
  localparam logic [30:0] T_ONE = 31'h4000_0000;
  // Unit of the blend weight, Q1.16.
  localparam logic [16:0] S_ONE = 17'h1_0000;

  // Steps of the divider: the fraction t has 30 quotient bits.
  localparam int unsigned    DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] T_STEPS = 6'd30;

  // One knot of the table as it sits in memory.
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] lvl;
    logic signed [31:0] grd;
  } lcbi_knot_t;

  // Control of one division run.
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } lcbi_div_ctl_t;

endpackage

`default_nettype wire

// ===== src/lcbi_div.sv =====
// Restoring long divider, one quotient bit per cycle, for the blend interpolator.
// Depends on lcbi_pkg for the control struct and the step counter width.
`default_nettype none

module lcbi_div #(
  parameter int unsigned NB = 51
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lcbi_pkg::lcbi_div_ctl_t       ctl_i,
  input  wire  [31:0]                   rem_init_i,
  input  wire  [NB-1:0]                 dividend_i,
  input  wire  [31:0]                   divisor_i,
  output logic                          busy_o,
  output logic [NB-1:0]                 quotient_o
);
  import lcbi_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [31:0]          rem_q;
  logic [31:0]          div_q;
  logic [NB-1:0]        dvd_q;
  logic [NB-1:0]        quo_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // The remainder always stays below the divisor, so 32 bits hold it.
  assign trial = {rem_q, dvd_q[NB-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= ctl_i.steps;
      rem_q  <= rem_init_i;
      div_q  <= divisor_i;
      dvd_q  <= dividend_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[NB-2:0], 1'b0};
      quo_q <= {quo_q[NB-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== src/linear_cubic_blend_interpolator.sv =====
// Top level of the linear / cubic Hermite blend interpolator over a knot table.
// Depends on lcbi_pkg and instantiates the long divider lcbi_div.
`default_nettype none

// Channel    Direction  Handshake                 Payload
// input      in         in_valid_i / in_stall_o   cmd, knot_slot, position, knot_level,
//                                                 knot_gradient, restart
// result     out        out_valid_o / out_stall_i value, derivative, status
// config     in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// A load item is written to the knot memory in the cycle of its transfer, so loads
// stream one per cycle while no query is in progress. A query holds the input stalled
// until it is done, and longer the more knots it walks: the one-bit-per-cycle divider
// sets most of that (30 quotient bits for the interval fraction, 35 + FRAC_BITS bits for
// the derivative quotient), and the rest is one shared multiplier used over twenty
// steps. A query whose fraction is 0 or 1 skips the first division, and an extrapolated
// query skips the walk and both divisions. The search pointer resets to the second knot.
// A result waits in the output register while out_stall_i is high; the next item may
// be accepted meanwhile, and only the final step of a query waits for it.

module linear_cubic_blend_interpolator #(
  parameter int unsigned KNOTS     = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // Configuration writes.
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire  [16:0]        cfg_data_i,
  // Input items.
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                cmd_i,
  input  wire  [5:0]         knot_slot_i,
  input  wire  signed [31:0] position_i,
  input  wire  signed [31:0] knot_level_i,
  input  wire  signed [31:0] knot_gradient_i,
  input  wire                restart_i,
  // Results.
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] value_o,
  output logic signed [31:0] derivative_o,
  output logic [1:0]         status_o
);
  import lcbi_pkg::*;

  localparam int unsigned AW     = (KNOTS > 2) ? $clog2(KNOTS) : 1;
  // Magnitude width of the derivative dividend after its shift by 30 - FRAC_BITS.
  localparam int unsigned DIV_NB = 35 + FRAC_BITS;
  localparam logic [4:0]  EVAL_LAST = 5'd19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_WALK,
    ST_RD_PREV,
    ST_RATIO,
    ST_DIV_T,
    ST_EVAL,
    ST_DIV_D,
    ST_EXTRAP,
    ST_EX_ADD,
    ST_FINISH
  } state_e;

  // Configuration registers.
  logic [6:0]  knots_q;
  logic [16:0] blend_q;

  // Control state.
  state_e        state_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] j_q;
  logic [4:0]    step_q;
  logic          out_valid_q;

  // Knot memory: one entry holds position, value and slope.
  lcbi_knot_t mem_q [KNOTS];
  lcbi_knot_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // Query data path.
  logic signed [31:0] x_q;
  lcbi_knot_t         first_q;
  lcbi_knot_t         ex_q;
  lcbi_knot_t         k0_q;
  lcbi_knot_t         k1_q;
  logic signed [32:0] h_q;
  logic signed [32:0] a_q;
  logic signed [32:0] dv_q;
  logic [30:0]        t_q;
  logic [30:0]        t2_q;
  logic [30:0]        t3_q;
  logic [30:0]        h10_q;
  logic [30:0]        h11_q;
  logic [30:0]        q_q;
  logic signed [67:0] acc_q;
  logic signed [33:0] w_q;
  logic signed [33:0] g_q;
  logic [15:0]        glo_q;
  logic signed [63:0] val_q;
  logic signed [63:0] der_q;
  logic signed [63:0] dadd_q;
  logic               qneg_q;
  logic [1:0]         res_stat_q;

  // Shared multiplier.
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod_q;

  // Output register.
  logic signed [31:0] value_q;
  logic signed [31:0] derivative_q;
  logic [1:0]         status_q;

  // Divider hookup.
  lcbi_div_ctl_t       div_ctl;
  logic [31:0]         div_rem_init;
  logic [DIV_NB-1:0]   div_dividend;
  logic                div_busy;
  logic [DIV_NB-1:0]   div_quo;

  // Derived values.
  logic [AW-1:0]      nm1;
  logic [AW-1:0]      jclamp;
  logic [16:0]        s_c;
  logic [16:0]        sb_c;
  logic [30:0]        u_c;
  logic [30:0]        prod_t30;
  logic signed [33:0] cub_c;
  logic signed [33:0] e0_c;
  logic signed [33:0] e1_c;
  logic signed [33:0] wd_c;
  logic signed [33:0] y_c;
  logic signed [63:0] wd_sum;
  logic signed [67:0] num_c;
  logic [31:0]        hmag;
  logic signed [33:0] amag;
  logic signed [32:0] ex_diff;
  logic               walk_more;
  logic signed [63:0] quo_s;
  logic               val_hi, val_lo, der_hi, der_lo;
  logic               in_take;

  // Effective knot count, clamped to [2, KNOTS]; nm1 is the index of the last knot.
  always_comb begin
    logic [31:0] n_eff;
    n_eff = 32'(knots_q);
    if (n_eff < 32'd2) begin
      n_eff = 32'd2;
    end
    if (n_eff > 32'(KNOTS)) begin
      n_eff = 32'(KNOTS);
    end
    nm1 = AW'(n_eff - 32'd1);
  end

  // The kept pointer is pulled into [1, n-1] before the walk starts.
  always_comb begin
    jclamp = ptr_q;
    if (jclamp == '0) begin
      jclamp = AW'(1);
    end
    if (jclamp > nm1) begin
      jclamp = nm1;
    end
  end

  assign s_c      = (blend_q > S_ONE) ? S_ONE : blend_q;
  assign sb_c     = S_ONE - s_c;
  assign u_c      = T_ONE - t_q;
  assign prod_t30 = 31'(prod_q >>> 30);

  // Hermite weights; they can dip slightly below zero, so they are kept signed.
  assign cub_c = $signed(34'(t2_q) + 34'(t2_q) + 34'(t2_q) - 34'(t3_q) - 34'(t3_q));
  assign e0_c  = $signed(34'(t2_q) + 34'(t2_q) + 34'(t2_q) - (34'(t_q) << 2) + 34'(T_ONE));
  assign e1_c  = $signed(34'(t2_q) + 34'(t2_q) + 34'(t2_q) - (34'(t_q) << 1));

  // Derivative blend weight: (1-s) * 1 + s * 6 * t * u, back to Q2.30.
  assign wd_sum = (64'(sb_c) << 30) + (64'(prod_q) << 2) + (64'(prod_q) << 1);
  assign wd_c   = 34'(wd_sum >>> 16);
  assign y_c    = 34'((acc_q + prod_q) >>> 30);
  assign num_c  = prod_q >>> (30 - FRAC_BITS);

  assign hmag    = h_q[32] ? 32'(-h_q) : 32'(h_q);
  assign amag    = h_q[32] ? -34'(a_q) : 34'(a_q);
  assign ex_diff = 33'(x_q) - 33'(ex_q.pos);

  assign walk_more = (j_q < nm1) && (rd_q.pos < x_q);
  assign in_take   = in_valid_i && !in_stall_o;

  // Memory read address; the data is registered and used in the next cycle.
  always_comb begin
    unique case (state_q)
      ST_RD_FIRST: rd_addr = nm1;
      ST_RD_LAST:  rd_addr = jclamp;
      ST_WALK:     rd_addr = walk_more ? j_q + 1'b1 : j_q - 1'b1;
      default:     rd_addr = '0;
    endcase
  end

  assign mem_we = (state_q == ST_IDLE) && in_valid_i && (cmd_i == CMD_LOAD) &&
                  (32'(knot_slot_i) < 32'(KNOTS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(knot_slot_i)] <= '{pos: position_i, lvl: knot_level_i, grd: knot_gradient_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Operand selection of the shared multiplier, one product per evaluation step.
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == ST_EXTRAP) begin
      ma = 34'(ex_diff);
      mb = 34'(ex_q.grd);
    end else if (state_q == ST_EVAL) begin
      case (step_q)
        5'd0:  begin ma = 34'(t_q);      mb = 34'(t_q);      end
        5'd1:  begin ma = 34'(prod_t30); mb = 34'(t_q);      end
        5'd2:  begin ma = 34'(u_c);      mb = 34'(u_c);      end
        5'd3:  begin ma = 34'(t_q);      mb = 34'(prod_t30); end
        5'd4:  begin ma = 34'(t2_q);     mb = 34'(u_c);      end
        5'd5:  begin ma = 34'(t_q);      mb = 34'(u_c);      end
        5'd6:  begin ma = 34'(sb_c);     mb = 34'(t_q);      end
        5'd7:  begin ma = 34'(s_c);      mb = cub_c;         end
        5'd8:  begin ma = 34'(k0_q.grd); mb = 34'(h10_q);    end
        5'd9:  begin ma = 34'(k1_q.grd); mb = 34'(h11_q);    end
        5'd10: begin ma = 34'(dv_q);     mb = w_q;           end
        5'd11: begin ma = 34'(h_q);      mb = g_q;           end
        5'd12: begin ma = 34'(s_c);      mb = 34'(prod_q >>> (FRAC_BITS + 16)); end
        5'd13: begin ma = 34'(s_c);      mb = 34'(glo_q);    end
        5'd14: begin ma = 34'(s_c);      mb = 34'(q_q);      end
        5'd15: begin ma = 34'(dv_q);     mb = wd_c;          end
        5'd16: begin ma = 34'(k0_q.grd); mb = e0_c;         end
        5'd17: begin ma = 34'(k1_q.grd); mb = e1_c;         end
        5'd18: begin ma = 34'(s_c);      mb = y_c;           end
        default: begin ma = '0;          mb = '0;            end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  // Divider requests: the interval fraction and later the derivative quotient.
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = T_STEPS;
    div_rem_init  = '0;
    div_dividend  = '0;
    if (state_q == ST_RATIO) begin
      div_ctl.start = (h_q != '0) && (amag > 34'sd0) && (amag < 34'(hmag));
      div_rem_init  = 32'(amag);
    end else if ((state_q == ST_EVAL) && (step_q == 5'd16)) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = DIV_CNT_W'(DIV_NB);
      div_dividend  = num_c[67] ? DIV_NB'(-num_c) : DIV_NB'(num_c);
    end
  end

  lcbi_div #(
    .NB (DIV_NB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (hmag),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Truncating division: quotient of magnitudes, sign applied afterwards.
  assign quo_s = qneg_q ? -64'(div_quo) : 64'(div_quo);

  assign val_hi = val_q > 64'sd2147483647;
  assign val_lo = val_q < -64'sd2147483648;
  assign der_hi = der_q > 64'sd2147483647;
  assign der_lo = der_q < -64'sd2147483648;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      knots_q     <= 7'd2;
      blend_q     <= '0;
      ptr_q       <= AW'(1);
      j_q         <= AW'(1);
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_KNOTS: knots_q <= cfg_data_i[6:0];
          CFG_BLEND: blend_q <= cfg_data_i;
          default:   blend_q <= blend_q;
        endcase
      end

      // The final step loads a new result itself, so it alone drives the flag then.
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_take && (cmd_i == CMD_QUERY)) begin
            x_q <= position_i;
            if (restart_i) begin
              ptr_q <= AW'(1);
            end
            state_q <= ST_RD_FIRST;
          end
        end

        ST_RD_FIRST: begin
          first_q <= rd_q;
          state_q <= ST_RD_LAST;
        end

        ST_RD_LAST: begin
          if (x_q <= first_q.pos) begin
            ex_q    <= first_q;
            state_q <= ST_EXTRAP;
          end else if (x_q > rd_q.pos) begin
            ex_q    <= rd_q;
            state_q <= ST_EXTRAP;
          end else begin
            j_q     <= jclamp;
            state_q <= ST_WALK;
          end
        end

        ST_WALK: begin
          if (walk_more) begin
            j_q <= j_q + 1'b1;
          end else begin
            ptr_q   <= j_q;
            k1_q    <= rd_q;
            state_q <= ST_RD_PREV;
          end
        end

        ST_RD_PREV: begin
          k0_q    <= rd_q;
          h_q     <= 33'(k1_q.pos) - 33'(rd_q.pos);
          a_q     <= 33'(x_q) - 33'(rd_q.pos);
          dv_q    <= 33'(k1_q.lvl) - 33'(rd_q.lvl);
          state_q <= ST_RATIO;
        end

        ST_RATIO: begin
          step_q <= '0;
          if (h_q == '0) begin
            val_q      <= '0;
            der_q      <= '0;
            res_stat_q <= STAT_ZERO;
            state_q    <= ST_FINISH;
          end else if (amag <= 34'sd0) begin
            t_q     <= '0;
            state_q <= ST_EVAL;
          end else if (amag >= 34'(hmag)) begin
            t_q     <= T_ONE;
            state_q <= ST_EVAL;
          end else begin
            state_q <= ST_DIV_T;
          end
        end

        ST_DIV_T: begin
          if (!div_busy) begin
            t_q     <= 31'(div_quo[29:0]);
            state_q <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            5'd1:  t2_q  <= prod_t30;
            5'd2:  t3_q  <= prod_t30;
            5'd4:  h10_q <= prod_t30;
            5'd5:  h11_q <= prod_t30;
            5'd6:  q_q   <= prod_t30;
            5'd7:  acc_q <= prod_q;
            5'd8:  w_q   <= 34'((acc_q + prod_q) >>> 16);
            5'd9:  acc_q <= prod_q;
            5'd10: g_q   <= 34'((acc_q - prod_q) >>> 30);
            5'd11: val_q <= 64'(k0_q.lvl) + 64'(prod_q >>> 30);
            5'd12: glo_q <= prod_q[FRAC_BITS+15:FRAC_BITS];
            5'd13: acc_q <= prod_q;
            // s * (hi * 2^16 + lo) split: the high part needs no rounding.
            5'd14: val_q <= val_q + 64'(acc_q) + 64'(prod_q >>> 16);
            5'd16: qneg_q <= num_c[67] ^ h_q[32];
            5'd17: acc_q <= prod_q;
            default: acc_q <= acc_q;
          endcase
          if (step_q == EVAL_LAST) begin
            dadd_q  <= 64'(prod_q >>> 16);
            state_q <= ST_DIV_D;
          end
        end

        ST_DIV_D: begin
          if (!div_busy) begin
            der_q      <= quo_s + dadd_q;
            res_stat_q <= STAT_OK;
            state_q    <= ST_FINISH;
          end
        end

        ST_EXTRAP: begin
          state_q <= ST_EX_ADD;
        end

        ST_EX_ADD: begin
          val_q      <= 64'(ex_q.lvl) + 64'(prod_q >>> FRAC_BITS);
          der_q      <= 64'(ex_q.grd);
          res_stat_q <= STAT_OK;
          state_q    <= ST_FINISH;
        end

        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            value_q      <= val_hi ? 32'sh7FFF_FFFF : (val_lo ? 32'sh8000_0000 : 32'(val_q));
            derivative_q <= der_hi ? 32'sh7FFF_FFFF : (der_lo ? 32'sh8000_0000 : 32'(der_q));
            status_q     <= ((res_stat_q == STAT_OK) && (val_hi || val_lo || der_hi || der_lo))
                            ? STAT_SAT : res_stat_q;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign derivative_o = derivative_q;
  assign status_o     = status_q;

  // The kept pointer never falls to the first knot.
  a_ptr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q != '0)
    else $error("search pointer reached zero");

  // The walk never steps past the last knot in use.
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (j_q <= nm1) && (j_q != '0))
    else $error("interval walk left the table");

  // A finished derivative division always leads straight to the result step.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_D) && !div_busy |=> (state_q == ST_FINISH))
    else $error("derivative division did not complete the query");

  // A status code that means nothing never reaches the output.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK) || (status_o == STAT_SAT) ||
                    (status_o == STAT_ZERO))
    else $error("invalid status on result");

endmodule

`default_nettype wire

// ===== bench/tb_linear_cubic_blend_interpolator.sv =====
// Self-checking testbench for linear_cubic_blend_interpolator. It runs directed and
// random knot loads and queries, and checks every result against a predictor or a typed expectation.
// Depends on lcbi_pkg and on the RTL of the block.
`timescale 1ns / 100ps

module tb_linear_cubic_blend_interpolator;
  import lcbi_pkg::*;

  // The interval fraction is Q1.30 and the blend weight is Q1.16.
  localparam longint UNIT_T = 64'sd1 << 30;
  localparam longint UNIT_S = 64'sd65536;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 2000000;
  // A query takes longer the more knots it walks.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;

  // One input item. Rows of the directed table may carry a typed expectation.
  typedef struct {
    logic               cmd;
    logic [5:0]         slot;
    logic signed [31:0] pos;
    logic signed [31:0] lvl;
    logic signed [31:0] grd;
    logic               rs;
    bit                 typed;
    logic signed [31:0] ev;
    logic signed [31:0] ed;
    logic [1:0]         es;
  } item_t;

  typedef struct {
    logic signed [31:0] v;
    logic signed [31:0] d;
    logic [1:0]         st;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [16:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic cmd_i;
  logic [5:0] knot_slot_i;
  logic signed [31:0] position_i;
  logic signed [31:0] knot_level_i;
  logic signed [31:0] knot_gradient_i;
  logic restart_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] value_o;
  logic signed [31:0] derivative_o;
  logic [1:0] status_o;

  linear_cubic_blend_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .knot_slot_i     (knot_slot_i),
    .position_i      (position_i),
    .knot_level_i    (knot_level_i),
    .knot_gradient_i (knot_gradient_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o),
    .derivative_o    (derivative_o),
    .status_o        (status_o)
  );

  // Mirror of the block's state, kept in step with every accepted transfer and register write.
  logic signed [31:0] knot_pos [64];
  logic signed [31:0] knot_lvl [64];
  logic signed [31:0] knot_grd [64];
  int unsigned walk_ptr;
  logic [6:0] knots_reg;
  logic [16:0] blend_reg;

  result_t pending_results[$];
  int errors;
  int idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Floor shift, as the block rounds every right shift toward minus infinity.
  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip32(longint v, ref bit clipped);
    if (v > MAX32) begin
      clipped = 1'b1;
      return MAX32;
    end
    if (v < MIN32) begin
      clipped = 1'b1;
      return MIN32;
    end
    return v;
  endfunction

  // Fraction t = a / h in Q1.30, clamped to [0, 1], from magnitudes.
  function automatic longint interval_frac(longint a, longint h);
    if (h < 0) begin
      a = -a;
      h = -h;
    end
    if (a <= 0) return 0;
    if (a >= h) return UNIT_T;
    return (a <<< 30) / h;
  endfunction

  // Value and derivative of the blended interpolant at one query position.
  // Also advances the kept search pointer, as the block does.
  function automatic result_t eval_blend(logic signed [31:0] xq, logic rs);
    longint n, s, x, val, der, p0, p1, v0, v1, d0, d1, h;
    longint t, u, sb, t2, t3, h10, h11, q, dv, w, g, wd, e0, e1;
    int unsigned j;
    bit clipped;
    result_t r;
    clipped = 1'b0;
    r.st = STAT_OK;
    n = knots_reg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    s = (blend_reg > UNIT_S) ? UNIT_S : blend_reg;
    x = xq;
    if (rs) walk_ptr = 1;
    if (x <= longint'(knot_pos[0])) begin
      val = knot_lvl[0] + fshift((x - knot_pos[0]) * knot_grd[0], 16);
      der = knot_grd[0];
    end else if (x > longint'(knot_pos[n-1])) begin
      val = knot_lvl[n-1] + fshift((x - knot_pos[n-1]) * knot_grd[n-1], 16);
      der = knot_grd[n-1];
    end else begin
      j = walk_ptr;
      if (j < 1) j = 1;
      if (j > n - 1) j = n - 1;
      while (j < n - 1 && longint'(knot_pos[j]) < x) j++;
      walk_ptr = j;
      p0 = knot_pos[j-1];
      p1 = knot_pos[j];
      v0 = knot_lvl[j-1];
      v1 = knot_lvl[j];
      d0 = knot_grd[j-1];
      d1 = knot_grd[j];
      h = p1 - p0;
      if (h == 0) begin
        val = 0;
        der = 0;
        r.st = STAT_ZERO;
      end else begin
        t = interval_frac(x - p0, h);
        u = UNIT_T - t;
        sb = UNIT_S - s;
        t2 = fshift(t * t, 30);
        t3 = fshift(t2 * t, 30);
        h10 = fshift(t * fshift(u * u, 30), 30);
        h11 = fshift(t2 * u, 30);
        q = fshift(t * u, 30);
        dv = v1 - v0;
        w = fshift(sb * t + s * (3 * t2 - 2 * t3), 16);
        g = fshift(d0 * h10 - d1 * h11, 30);
        wd = fshift(sb * UNIT_T + s * 6 * q, 16);
        e0 = 3 * t2 - 4 * t + UNIT_T;
        e1 = 3 * t2 - 2 * t;
        val = v0 + fshift(dv * w, 30) + fshift(s * fshift(h * g, 16), 16);
        der = fshift(dv * wd, 14) / h + fshift(s * fshift(d0 * e0 + d1 * e1, 30), 16);
      end
    end
    val = clip32(val, clipped);
    der = clip32(der, clipped);
    if (clipped && r.st == STAT_OK) r.st = STAT_SAT;
    r.v = val[31:0];
    r.d = der[31:0];
    return r;
  endfunction

  // Result side: checks each transfer, then picks the stall for the next cycle.
  // A long hold-off, when requested, is counted out here while the sender keeps
  // offering items, so the block fills up and stalls its input.
  initial begin
    result_t want;
    out_stall_i = 1'b0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value %0d derivative %0d status %0d",
                   $time, value_o, derivative_o, status_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (value_o !== want.v) begin
            $display("%0t: value expected %0d actual %0d", $time, want.v, value_o);
            errors++;
          end
          if (derivative_o !== want.d) begin
            $display("%0t: derivative expected %0d actual %0d", $time, want.d,
                     derivative_o);
            errors++;
          end
          if (status_o !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
            errors++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one item, waits for its transfer, then updates the predictor.
  // Called at a rising edge and returns at the edge of the transfer.
  task automatic send_item(item_t it);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    knot_slot_i <= it.slot;
    position_i <= it.pos;
    knot_level_i <= it.lvl;
    knot_gradient_i <= it.grd;
    restart_i <= it.rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.cmd == CMD_LOAD) begin
      knot_pos[it.slot] = it.pos;
      knot_lvl[it.slot] = it.lvl;
      knot_grd[it.slot] = it.grd;
    end else begin
      r = eval_blend(it.pos, it.rs);
      if (it.typed) begin
        r.v = it.ev;
        r.d = it.ed;
        r.st = it.es;
      end
      pending_results.push_back(r);
    end
  endtask

  // Waits for the block to go idle, then writes one register.
  task automatic write_reg(logic idx, logic [16:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KNOTS) knots_reg = data[6:0];
    else blend_reg = data;
  endtask

  function automatic item_t load_row(logic [5:0] slot, logic signed [31:0] pos,
                                     logic signed [31:0] lvl, logic signed [31:0] grd,
                                     logic rs);
    item_t it;
    it = '{cmd: CMD_LOAD, slot: slot, pos: pos, lvl: lvl, grd: grd, rs: rs,
           typed: 1'b0, ev: 0, ed: 0, es: STAT_OK};
    return it;
  endfunction

  function automatic item_t query_row(logic signed [31:0] pos, logic rs, bit typed,
                                      logic signed [31:0] ev, logic signed [31:0] ed,
                                      logic [1:0] es);
    item_t it;
    it = '{cmd: CMD_QUERY, slot: 6'($urandom), pos: pos, lvl: $urandom, grd: $urandom,
           rs: rs, typed: typed, ev: ev, ed: ed, es: es};
    return it;
  endfunction

  function automatic logic signed [31:0] rand_word(int big_pct, int small_bits);
    if ($urandom_range(99) < big_pct) return $urandom;
    return $signed($urandom_range((1 << small_bits) - 1)) - (1 << (small_bits - 1));
  endfunction

  // One random phase: register setting, idling and stall mix, then repeated rounds of a fresh
  // mostly ascending table followed by a sweep of queries with some noise mixed in.
  task automatic run_phase(logic [6:0] knots, logic [16:0] blend, int idle, int stall,
                           int budget, bit pressure);
    int n_eff, sent, nq, span_step;
    longint p, x, lo, hi, step;
    item_t it;
    write_reg(CFG_KNOTS, {10'd0, knots});
    write_reg(CFG_BLEND, blend);
    idle_pct = idle;
    stall_pct = stall;
    n_eff = (knots < 2) ? 2 : ((knots > 64) ? 64 : knots);
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(2))
        0: span_step = 16;
        1: span_step = 1 << 17;
        default: span_step = 1 << 24;
      endcase
      p = -longint'($urandom_range(32'h4000_0000));
      for (int i = 0; i < n_eff; i++) begin
        // Mostly ascending, with the odd repeated or falling knot.
        case ($urandom_range(49))
          0: step = 0;
          1: step = -longint'($urandom_range(span_step));
          default: step = 1 + $urandom_range(span_step);
        endcase
        if (i > 0) p = p + step;
        send_item(load_row(6'(i), p[31:0], rand_word(30, 21), rand_word(30, 21),
                           1'($urandom)));
        sent++;
      end
      if ($urandom_range(3) == 0) begin
        send_item(load_row(6'($urandom_range(n_eff, 63)), $urandom, $urandom, $urandom,
                           1'($urandom)));
        sent++;
      end
      if (pressure) hold_requests++;
      pressure = 1'b0;
      lo = longint'(knot_pos[0]) - 2 * span_step;
      hi = longint'(knot_pos[n_eff-1]) + 2 * span_step;
      nq = $urandom_range(4, 40);
      x = lo;
      for (int k = 0; k < nq; k++) begin
        if (k > 0 && $urandom_range(9) == 0) begin
          it = query_row($urandom, 1'($urandom), 1'b0, 0, 0, STAT_OK);
        end else begin
          if (x < MIN32) x = MIN32;
          if (x > MAX32) x = MAX32;
          it = query_row(x[31:0], k == 0, 1'b0, 0, 0, STAT_OK);
          x = x + $urandom_range(32'h7fff_ffff) % ((hi - lo) / (nq / 2 + 1) + 1);
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  item_t directed[$];

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    walk_ptr = 1;
    knots_reg = 7'd2;
    blend_reg = 17'd0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_KNOTS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_LOAD;
    knot_slot_i = '0;
    position_i = '0;
    knot_level_i = '0;
    knot_gradient_i = '0;
    restart_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three knots are needed to build a zero-width interval.
    write_reg(CFG_KNOTS, 17'd3);
    // Fill the whole table so no query can ever read an unwritten slot.
    for (int i = 0; i < 64; i++)
      send_item(load_row(6'(i), i * 32'h1_0000, rand_word(50, 20), rand_word(50, 20),
                         1'b0));

    directed.push_back(load_row(0, 32'h0, 32'h1_0000, 32'h2_0000, 1'b0));
    directed.push_back(load_row(1, 32'h1_0000, 32'h3_0000, 32'h0, 1'b0));
    // A restart flag on a load has no effect.
    directed.push_back(load_row(2, 32'h2_0000, 32'h3_0000, 32'h1_0000, 1'b1));
    // Below the first knot and exactly on it: the line through the first knot.
    directed.push_back(query_row(-32'sh1_0000, 1'b1, 1'b1, -32'sh1_0000, 32'h2_0000,
                                 STAT_OK));
    directed.push_back(query_row(32'h0, 1'b0, 1'b1, 32'h1_0000, 32'h2_0000, STAT_OK));
    directed.push_back(query_row(32'h8000, 1'b1, 1'b0, 0, 0, STAT_OK));
    directed.push_back(query_row(32'h1_0000, 1'b0, 1'b0, 0, 0, STAT_OK));
    // This one leaves the search pointer on the last interval.
    directed.push_back(query_row(32'h1_8000, 1'b0, 1'b0, 0, 0, STAT_OK));
    // Above the last knot: the line through the last knot, then saturated.
    directed.push_back(query_row(32'h3_0000, 1'b0, 1'b1, 32'h4_0000, 32'h1_0000,
                                 STAT_OK));
    directed.push_back(query_row(32'h7fff_ffff, 1'b0, 1'b1, 32'h7fff_ffff, 32'h1_0000,
                                 STAT_SAT));
    // Moving the middle knot onto the last one makes the kept interval zero wide.
    directed.push_back(load_row(1, 32'h2_0000, 32'h0, 32'h0, 1'b0));
    directed.push_back(query_row(32'h1_8000, 1'b0, 1'b1, 32'h0, 32'h0, STAT_ZERO));
    directed.push_back(query_row(32'h1_8000, 1'b1, 1'b0, 0, 0, STAT_OK));
    // Extreme knot fields.
    directed.push_back(load_row(0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
    directed.push_back(query_row(32'h8000_0000, 1'b0, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff,
                                 STAT_OK));
    directed.push_back(load_row(0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
    directed.push_back(query_row(32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 32'h7fff_ffff,
                                 STAT_SAT));
    directed.push_back(load_row(63, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
    directed.push_back(query_row(32'h1_0000, 1'b1, 1'b0, 0, 0, STAT_OK));
    foreach (directed[i]) send_item(directed[i]);

    // Register settings sweep both ends and the out-of-range values.
    run_phase(7'd2, 17'd0, 0, 0, 210, 1'b0);
    run_phase(7'd64, 17'd65536, 50, 0, 210, 1'b0);
    run_phase(7'd5, 17'd32768, 0, 50, 210, 1'b0);
    run_phase(7'd17, 17'd131071, 34, 34, 210, 1'b0);
    run_phase(7'd1, 17'd12345, 0, 0, 210, 1'b1);
    run_phase(7'd100, 17'd65535, 50, 0, 210, 1'b0);
    run_phase(7'd33, 17'd1, 0, 50, 210, 1'b0);
    run_phase(7'd0, 17'd40000, 34, 34, 210, 1'b0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
